### rtl/scqe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package scqe_pkg;

    localparam int CW    = 16;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;
    localparam int NW    = PW + 1;
    localparam int MW    = NW - 1;
    localparam int LW    = (MW + 1) / 2;
    localparam int HW    = MW - LW;
    localparam int NUMW  = CW + MW;
    localparam int QW    = CW;
    localparam int NEDGE = 4;
    localparam int EW    = 2;

    localparam logic [EW-1:0] EDGE_AB = 2'd0;
    localparam logic [EW-1:0] EDGE_BC = 2'd1;
    localparam logic [EW-1:0] EDGE_CD = 2'd2;
    localparam logic [EW-1:0] EDGE_AD = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] seg_start_x;
        logic signed [CW-1:0] seg_start_y;
        logic signed [CW-1:0] seg_end_x;
        logic signed [CW-1:0] seg_end_y;
        logic signed [CW-1:0] corner_a_x;
        logic signed [CW-1:0] corner_a_y;
        logic signed [CW-1:0] corner_b_x;
        logic signed [CW-1:0] corner_b_y;
        logic signed [CW-1:0] corner_c_x;
        logic signed [CW-1:0] corner_c_y;
        logic signed [CW-1:0] corner_d_x;
        logic signed [CW-1:0] corner_d_y;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0] clip_x;
        logic signed [CW-1:0] clip_y;
        logic                 hit;
        logic [EW-1:0]        edge_index;
    } t_out;

    typedef struct packed {
        logic                 hit;
        logic [EW-1:0]        edge_sel;
        logic                 neg_x;
        logic                 neg_y;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        logic [MW-1:0]        den;
        logic [NUMW-1:0]      rem_x;
        logic [NUMW-1:0]      rem_y;
        logic [QW-1:0]        q_x;
        logic [QW-1:0]        q_y;
    } t_div;

    function automatic logic [EW-1:0] edge_first(input logic [EW-1:0] k);
        case (k)
            EDGE_AB: edge_first = 2'd0;
            EDGE_BC: edge_first = 2'd1;
            EDGE_CD: edge_first = 2'd2;
            EDGE_AD: edge_first = 2'd0;
            default: edge_first = 2'd0;
        endcase
    endfunction

    function automatic logic [EW-1:0] edge_second(input logic [EW-1:0] k);
        case (k)
            EDGE_AB: edge_second = 2'd1;
            EDGE_BC: edge_second = 2'd2;
            EDGE_CD: edge_second = 2'd3;
            EDGE_AD: edge_second = 2'd3;
            default: edge_second = 2'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

### rtl/segment_clip_to_quad_edges.sv
`timescale 1ns / 1ps
`default_nettype none
// Clips a segment against the edges ab, bc, cd, ad of a quad; of the crossed edges, the first in that order wins.
// One word enters per cycle; the output word is formed by a bit-per-stage pipelined
// divider that forms (end - start) * num / den for x and y. The whole pipeline
// holds while the output word is stalled.
module segment_clip_to_quad_edges (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire scqe_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire                 i_stall,
    output scqe_pkg::t_out      o_data
);
    import scqe_pkg::*;

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    logic signed [CW-1:0] cx [NEDGE];
    logic signed [CW-1:0] cy [NEDGE];
    assign cx[0] = i_data.corner_a_x;
    assign cy[0] = i_data.corner_a_y;
    assign cx[1] = i_data.corner_b_x;
    assign cy[1] = i_data.corner_b_y;
    assign cx[2] = i_data.corner_c_x;
    assign cy[2] = i_data.corner_c_y;
    assign cx[3] = i_data.corner_d_x;
    assign cy[3] = i_data.corner_d_y;

    // stage 1: differences
    logic                 r1_v;
    logic signed [DW-1:0] r1_dax, r1_day;
    logic signed [DW-1:0] r1_dbx [NEDGE];
    logic signed [DW-1:0] r1_dby [NEDGE];
    logic signed [DW-1:0] r1_ox  [NEDGE];
    logic signed [DW-1:0] r1_oy  [NEDGE];
    logic signed [CW-1:0] r1_sx, r1_sy, r1_ex, r1_ey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_sx  <= i_data.seg_start_x;
            r1_sy  <= i_data.seg_start_y;
            r1_ex  <= i_data.seg_end_x;
            r1_ey  <= i_data.seg_end_y;
            r1_dax <= $signed({i_data.seg_end_x[CW-1], i_data.seg_end_x})
                    - $signed({i_data.seg_start_x[CW-1], i_data.seg_start_x});
            r1_day <= $signed({i_data.seg_end_y[CW-1], i_data.seg_end_y})
                    - $signed({i_data.seg_start_y[CW-1], i_data.seg_start_y});
            for (int k = 0; k < NEDGE; k++) begin
                r1_dbx[k] <= $signed({cx[edge_second(EW'(k))][CW-1], cx[edge_second(EW'(k))]})
                           - $signed({cx[edge_first(EW'(k))][CW-1], cx[edge_first(EW'(k))]});
                r1_dby[k] <= $signed({cy[edge_second(EW'(k))][CW-1], cy[edge_second(EW'(k))]})
                           - $signed({cy[edge_first(EW'(k))][CW-1], cy[edge_first(EW'(k))]});
                r1_ox[k]  <= $signed({i_data.seg_start_x[CW-1], i_data.seg_start_x})
                           - $signed({cx[edge_first(EW'(k))][CW-1], cx[edge_first(EW'(k))]});
                r1_oy[k]  <= $signed({i_data.seg_start_y[CW-1], i_data.seg_start_y})
                           - $signed({cy[edge_first(EW'(k))][CW-1], cy[edge_first(EW'(k))]});
            end
        end
    end

    // stage 2: cross product terms
    logic                 r2_v;
    logic signed [DW-1:0] r2_dax, r2_day;
    logic signed [PW-1:0] r2_d1 [NEDGE];
    logic signed [PW-1:0] r2_d2 [NEDGE];
    logic signed [PW-1:0] r2_a1 [NEDGE];
    logic signed [PW-1:0] r2_a2 [NEDGE];
    logic signed [PW-1:0] r2_b1 [NEDGE];
    logic signed [PW-1:0] r2_b2 [NEDGE];
    logic signed [CW-1:0] r2_sx, r2_sy, r2_ex, r2_ey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sx  <= r1_sx;
            r2_sy  <= r1_sy;
            r2_ex  <= r1_ex;
            r2_ey  <= r1_ey;
            r2_dax <= r1_dax;
            r2_day <= r1_day;
            for (int k = 0; k < NEDGE; k++) begin
                r2_d1[k] <= r1_dby[k] * r1_dax;
                r2_d2[k] <= r1_dbx[k] * r1_day;
                r2_a1[k] <= r1_dbx[k] * r1_oy[k];
                r2_a2[k] <= r1_dby[k] * r1_ox[k];
                r2_b1[k] <= r1_dax * r1_oy[k];
                r2_b2[k] <= r1_day * r1_ox[k];
            end
        end
    end

    // stage 3: denominators and numerators
    logic                 r3_v;
    logic signed [DW-1:0] r3_dax, r3_day;
    logic signed [NW-1:0] r3_den [NEDGE];
    logic signed [NW-1:0] r3_na  [NEDGE];
    logic signed [NW-1:0] r3_nb  [NEDGE];
    logic signed [CW-1:0] r3_sx, r3_sy, r3_ex, r3_ey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_sx  <= r2_sx;
            r3_sy  <= r2_sy;
            r3_ex  <= r2_ex;
            r3_ey  <= r2_ey;
            r3_dax <= r2_dax;
            r3_day <= r2_day;
            for (int k = 0; k < NEDGE; k++) begin
                r3_den[k] <= $signed({r2_d1[k][PW-1], r2_d1[k]})
                           - $signed({r2_d2[k][PW-1], r2_d2[k]});
                r3_na[k]  <= $signed({r2_a1[k][PW-1], r2_a1[k]})
                           - $signed({r2_a2[k][PW-1], r2_a2[k]});
                r3_nb[k]  <= $signed({r2_b1[k][PW-1], r2_b1[k]})
                           - $signed({r2_b2[k][PW-1], r2_b2[k]});
            end
        end
    end

    // stage 4: range test and first edge select
    logic                 n4_hit;
    logic [EW-1:0]        n4_edge;
    logic signed [NW-1:0] n4_na, n4_den;
    logic [NEDGE-1:0]     edge_ok;

    always_comb begin
        n4_hit  = 1'b0;
        n4_edge = EDGE_AB;
        n4_na   = r3_na[0];
        n4_den  = r3_den[0];
        for (int k = 0; k < NEDGE; k++) begin
            if (r3_den[k] > 0) begin
                edge_ok[k] = r3_na[k] >= 0 && r3_na[k] <= r3_den[k]
                          && r3_nb[k] >= 0 && r3_nb[k] <= r3_den[k];
            end else if (r3_den[k] < 0) begin
                edge_ok[k] = r3_na[k] <= 0 && r3_na[k] >= r3_den[k]
                          && r3_nb[k] <= 0 && r3_nb[k] >= r3_den[k];
            end else begin
                edge_ok[k] = 1'b0;
            end
        end
        for (int k = NEDGE - 1; k >= 0; k--) begin
            if (edge_ok[k]) begin
                n4_hit  = 1'b1;
                n4_edge = EW'(k);
                n4_na   = r3_na[k];
                n4_den  = r3_den[k];
            end
        end
    end

    logic                 r4_v, r4_hit;
    logic [EW-1:0]        r4_edge;
    logic signed [NW-1:0] r4_na, r4_den;
    logic signed [DW-1:0] r4_dax, r4_day;
    logic signed [CW-1:0] r4_sx, r4_sy, r4_ex, r4_ey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_hit  <= n4_hit;
            r4_edge <= n4_edge;
            r4_na   <= n4_na;
            r4_den  <= n4_den;
            r4_dax  <= r3_dax;
            r4_day  <= r3_day;
            r4_sx   <= r3_sx;
            r4_sy   <= r3_sy;
            r4_ex   <= r3_ex;
            r4_ey   <= r3_ey;
        end
    end

    // stage 5: magnitudes and split products
    logic [DW-1:0] abs_dax, abs_day;
    logic [NW-1:0] abs_na, abs_den;
    assign abs_dax = r4_dax[DW-1] ? DW'(-r4_dax) : DW'(r4_dax);
    assign abs_day = r4_day[DW-1] ? DW'(-r4_day) : DW'(r4_day);
    assign abs_na  = r4_na[NW-1]  ? NW'(-r4_na)  : NW'(r4_na);
    assign abs_den = r4_den[NW-1] ? NW'(-r4_den) : NW'(r4_den);

    logic                 r5_v, r5_hit, r5_neg_x, r5_neg_y;
    logic [EW-1:0]        r5_edge;
    logic [MW-1:0]        r5_den;
    logic [CW+LW-1:0]     r5_lo_x, r5_lo_y;
    logic [CW+HW-1:0]     r5_hi_x, r5_hi_y;
    logic signed [CW-1:0] r5_sx, r5_sy, r5_ex, r5_ey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_hit   <= r4_hit;
            r5_edge  <= r4_edge;
            r5_neg_x <= r4_dax[DW-1] ^ r4_na[NW-1] ^ r4_den[NW-1];
            r5_neg_y <= r4_day[DW-1] ^ r4_na[NW-1] ^ r4_den[NW-1];
            r5_den   <= abs_den[MW-1:0];
            r5_lo_x  <= abs_dax[CW-1:0] * abs_na[LW-1:0];
            r5_lo_y  <= abs_day[CW-1:0] * abs_na[LW-1:0];
            r5_hi_x  <= abs_dax[CW-1:0] * abs_na[MW-1:LW];
            r5_hi_y  <= abs_day[CW-1:0] * abs_na[MW-1:LW];
            r5_sx    <= r4_sx;
            r5_sy    <= r4_sy;
            r5_ex    <= r4_ex;
            r5_ey    <= r4_ey;
        end
    end

    // stage 6 feeds the divider, one quotient bit per stage after it
    logic r_dv  [QW+1];
    t_div r_div [QW+1];
    t_div n_div [QW+1];

    always_comb begin
        n_div[0].hit      = r5_hit;
        n_div[0].edge_sel = r5_edge;
        n_div[0].neg_x    = r5_neg_x;
        n_div[0].neg_y    = r5_neg_y;
        n_div[0].sx       = r5_sx;
        n_div[0].sy       = r5_sy;
        n_div[0].ex       = r5_ex;
        n_div[0].ey       = r5_ey;
        n_div[0].den      = r5_den;
        n_div[0].rem_x    = (NUMW'(r5_hi_x) << LW) + NUMW'(r5_lo_x);
        n_div[0].rem_y    = (NUMW'(r5_hi_y) << LW) + NUMW'(r5_lo_y);
        n_div[0].q_x      = '0;
        n_div[0].q_y      = '0;
    end

    for (genvar i = 0; i < QW; i++) begin : g_div
        logic [NUMW-1:0] trial;
        logic            ge_x, ge_y;
        assign trial = NUMW'(r_div[i].den) << (QW - 1 - i);
        assign ge_x  = r_div[i].rem_x >= trial;
        assign ge_y  = r_div[i].rem_y >= trial;
        always_comb begin
            n_div[i+1]       = r_div[i];
            n_div[i+1].rem_x = ge_x ? r_div[i].rem_x - trial : r_div[i].rem_x;
            n_div[i+1].rem_y = ge_y ? r_div[i].rem_y - trial : r_div[i].rem_y;
            n_div[i+1].q_x   = {r_div[i].q_x[QW-2:0], ge_x};
            n_div[i+1].q_y   = {r_div[i].q_y[QW-2:0], ge_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= QW; i++) begin
                r_dv[i] <= 1'b0;
            end
        end else if (en) begin
            r_dv[0] <= r5_v;
            for (int i = 0; i < QW; i++) begin
                r_dv[i+1] <= r_dv[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i <= QW; i++) begin
                r_div[i] <= n_div[i];
            end
        end
    end

    // output word
    logic signed [CW:0] t_x, t_y, sum_x, sum_y;
    t_out n_out;
    t_out r_out;
    logic r_ov;

    always_comb begin
        t_x   = r_div[QW].neg_x ? -$signed({1'b0, r_div[QW].q_x}) : $signed({1'b0, r_div[QW].q_x});
        t_y   = r_div[QW].neg_y ? -$signed({1'b0, r_div[QW].q_y}) : $signed({1'b0, r_div[QW].q_y});
        sum_x = $signed({r_div[QW].sx[CW-1], r_div[QW].sx}) + t_x;
        sum_y = $signed({r_div[QW].sy[CW-1], r_div[QW].sy}) + t_y;
        if (r_div[QW].hit) begin
            n_out.clip_x     = sum_x[CW-1:0];
            n_out.clip_y     = sum_y[CW-1:0];
            n_out.hit        = 1'b1;
            n_out.edge_index = r_div[QW].edge_sel;
        end else begin
            n_out.clip_x     = r_div[QW].ex;
            n_out.clip_y     = r_div[QW].ey;
            n_out.hit        = 1'b0;
            n_out.edge_index = EDGE_AB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_miss_edge_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.hit |-> o_data.edge_index == EDGE_AB)
        else $error("edge index set without hit");

    a_sel_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_v && r4_hit |-> r4_den != 0)
        else $error("hit selected on zero denominator");

    a_div_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[QW] && r_div[QW].hit |->
            r_div[QW].rem_x < NUMW'(r_div[QW].den) && r_div[QW].rem_y < NUMW'(r_div[QW].den))
        else $error("divider remainder not reduced");
`endif

endmodule
`default_nettype wire

### verif/tb_segment_clip_to_quad_edges.sv
`timescale 1ns / 1ps
module tb_segment_clip_to_quad_edges;
    import scqe_pkg::*;

    class clip_scoreboard;
        t_out pending[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function automatic logic [2*CW-1:0] clip_point(
            input longint sx, input longint sy, input longint ex, input longint ey,
            input longint ax, input longint ay, input longint bx, input longint by,
            output bit crossed);
            longint dax, day, dbx, dby, ox, oy, den, na, nb, px, py;
            bit ok;
            dax = ex - sx; day = ey - sy;
            dbx = bx - ax; dby = by - ay;
            ox = sx - ax; oy = sy - ay;
            den = dby * dax - dbx * day;
            crossed = 1'b0;
            clip_point = '0;
            if (den != 0) begin
                na = dbx * oy - dby * ox;
                nb = dax * oy - day * ox;
                if (den > 0)
                    ok = na >= 0 && na <= den && nb >= 0 && nb <= den;
                else
                    ok = na <= 0 && na >= den && nb <= 0 && nb >= den;
                if (ok) begin
                    px = sx + (dax * na) / den;
                    py = sy + (day * na) / den;
                    crossed = 1'b1;
                    clip_point = {px[CW-1:0], py[CW-1:0]};
                end
            end
        endfunction

        function void note_word(t_in w);
            longint cx[4], cy[4];
            int first[4], second[4];
            t_out r;
            bit crossed;
            logic [2*CW-1:0] pt;
            first = '{0, 1, 2, 0};
            second = '{1, 2, 3, 3};
            cx = '{w.corner_a_x, w.corner_b_x, w.corner_c_x, w.corner_d_x};
            cy = '{w.corner_a_y, w.corner_b_y, w.corner_c_y, w.corner_d_y};
            r.clip_x = w.seg_end_x;
            r.clip_y = w.seg_end_y;
            r.hit = 1'b0;
            r.edge_index = EDGE_AB;
            for (int k = 0; k < NEDGE; k++) begin
                pt = clip_point(w.seg_start_x, w.seg_start_y, w.seg_end_x, w.seg_end_y,
                                cx[first[k]], cy[first[k]], cx[second[k]],
                                cy[second[k]], crossed);
                if (crossed) begin
                    r.clip_x = pt[2*CW-1:CW];
                    r.clip_y = pt[CW-1:0];
                    r.hit = 1'b1;
                    r.edge_index = k[EW-1:0];
                    break;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_word(t_out got);
            t_out exp_w;
            if (pending.size() == 0) begin
                $error("unexpected word %h", got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.clip_x !== exp_w.clip_x) begin
                $error("clip_x exp %0d got %0d", exp_w.clip_x, got.clip_x);
                errors++;
            end
            if (got.clip_y !== exp_w.clip_y) begin
                $error("clip_y exp %0d got %0d", exp_w.clip_y, got.clip_y);
                errors++;
            end
            if (got.hit !== exp_w.hit) begin
                $error("hit exp %0d got %0d", exp_w.hit, got.hit);
                errors++;
            end
            if (got.edge_index !== exp_w.edge_index) begin
                $error("edge_index exp %0d got %0d", exp_w.edge_index, got.edge_index);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in  i_data = '0;
    logic o_stall, o_valid;
    t_out o_data;

    clip_scoreboard sb = new();
    int send_idle = 0;
    int recv_stall = 0;
    int hold_off = 0;

    segment_clip_to_quad_edges uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("** segment_clip_to_quad_edges: FAILED **");
        $finish;
    end

    // receiver side
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_word(o_data);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall);
        end
    end

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(5))
            0: rand_coord = 16'sh7fff;
            1: rand_coord = 16'sh8000;
            2: rand_coord = CW'($urandom_range(40) - 20);
            default: rand_coord = CW'($urandom);
        endcase
    endfunction

    function automatic t_in rand_word();
        t_in w;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(3) != 0) begin
            // small box around the origin plus a segment starting near the origin
            w.corner_a_x = CW'(-$urandom_range(3000)); w.corner_a_y = CW'(-$urandom_range(3000));
            w.corner_b_x = CW'($urandom_range(3000));  w.corner_b_y = CW'(-$urandom_range(3000));
            w.corner_c_x = CW'($urandom_range(3000));  w.corner_c_y = CW'($urandom_range(3000));
            w.corner_d_x = CW'(-$urandom_range(3000)); w.corner_d_y = CW'($urandom_range(3000));
            w.seg_start_x = CW'($urandom_range(400) - 200);
            w.seg_start_y = CW'($urandom_range(400) - 200);
            w.seg_end_x = rand_coord();
            w.seg_end_y = rand_coord();
        end else if ($urandom_range(1)) begin
            w.seg_start_x = rand_coord(); w.seg_start_y = rand_coord();
            w.seg_end_x = rand_coord();   w.seg_end_y = rand_coord();
            w.corner_a_x = rand_coord();  w.corner_c_y = rand_coord();
        end
        return w;
    endfunction

    task automatic send_word(t_in w);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_word(w);
    endtask

    task automatic mk_sq(output t_in w, input int sx, sy, ex, ey);
        w.seg_start_x = CW'(sx); w.seg_start_y = CW'(sy);
        w.seg_end_x = CW'(ex);   w.seg_end_y = CW'(ey);
        w.corner_a_x = -16'sd100; w.corner_a_y = -16'sd100;
        w.corner_b_x = 16'sd100;  w.corner_b_y = -16'sd100;
        w.corner_c_x = 16'sd100;  w.corner_c_y = 16'sd100;
        w.corner_d_x = -16'sd100; w.corner_d_y = 16'sd100;
    endtask

    initial begin
        t_in w;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: each edge, corners, touching ends, parallel, degenerate, extremes
        mk_sq(w, 0, 0, 0, -300); send_word(w);
        mk_sq(w, 0, 0, 300, 7);  send_word(w);
        mk_sq(w, 0, 0, 5, 300);  send_word(w);
        mk_sq(w, 0, 0, -300, 3); send_word(w);
        mk_sq(w, 0, 0, 300, 300); send_word(w);
        mk_sq(w, 0, 0, 0, -100);  send_word(w);
        mk_sq(w, 0, -100, 0, -300); send_word(w);
        mk_sq(w, 0, 0, 50, 50);   send_word(w);
        mk_sq(w, 7, 7, 7, 7);     send_word(w);
        mk_sq(w, -200, -100, 200, -100); send_word(w);
        mk_sq(w, -150, -100, -120, -100); send_word(w);
        mk_sq(w, 0, 0, 32767, -32768); send_word(w);
        mk_sq(w, 0, 0, -32768, 32767); send_word(w);
        w = {12{16'sh8000}}; send_word(w);
        w = {12{16'sh7fff}}; send_word(w);
        w = {6{16'sh7fff, 16'sh8000}}; send_word(w);
        w = {16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000,
             16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000};
        send_word(w);
        w = {16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
             16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff};
        send_word(w);
        w = '1; send_word(w);
        w = '0; send_word(w);
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 52; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 52; end
                3: begin send_idle = 34; recv_stall = 34; end
                default: begin send_idle = 0; recv_stall = 0; hold_off = 200; end
            endcase
            repeat (270) send_word(rand_word());
        end
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0)
            $display("** segment_clip_to_quad_edges: PASSED **");
        else
            $display("** segment_clip_to_quad_edges: FAILED **");
        $finish;
    end
endmodule

### filelist.f
rtl/scqe_pkg.sv
rtl/segment_clip_to_quad_edges.sv
verif/tb_segment_clip_to_quad_edges.sv
